>>> src/clce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clce_pkg
// Types, codes and the microcode table of the character LCD command encoder.
// ----------------------------------------------------------------------------
package clce_pkg;

  // request codes
  localparam logic [3:0] REQ_INIT      = 4'd0;
  localparam logic [3:0] REQ_CONTROL   = 4'd1;
  localparam logic [3:0] REQ_CHAR      = 4'd2;
  localparam logic [3:0] REQ_NUMBER    = 4'd3;
  localparam logic [3:0] REQ_CURSOR    = 4'd4;
  localparam logic [3:0] REQ_CLEAR     = 4'd5;
  localparam logic [3:0] REQ_HOME      = 4'd6;
  localparam logic [3:0] REQ_DISP_LEFT = 4'd7;
  localparam logic [3:0] REQ_DISP_RGHT = 4'd8;
  localparam logic [3:0] REQ_CUR_LEFT  = 4'd9;
  localparam logic [3:0] REQ_CUR_RGHT  = 4'd10;
  localparam logic [3:0] REQ_GLYPH     = 4'd11;

  // configuration register indexes
  localparam logic [2:0] CFG_DISPLAY_ON   = 3'd0;
  localparam logic [2:0] CFG_CURSOR_ON    = 3'd1;
  localparam logic [2:0] CFG_CURSOR_BLINK = 3'd2;
  localparam logic [2:0] CFG_TWO_LINES    = 3'd3;
  localparam logic [2:0] CFG_TALL_FONT    = 3'd4;
  localparam logic [2:0] CFG_WIDE_BUS     = 3'd5;

  // bus bytes
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_DISP_CTRL = 8'h08;
  localparam logic [7:0] CMD_FSET_8BIT = 8'h30;
  localparam logic [7:0] CMD_FSET_4BIT = 8'h10;
  localparam logic [7:0] CMD_DISP_LEFT = 8'h18;
  localparam logic [7:0] CMD_DISP_RGHT = 8'h1C;
  localparam logic [7:0] CMD_CUR_LEFT  = 8'h10;
  localparam logic [7:0] CMD_CUR_RGHT  = 8'h14;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [3:0] GLYPH_ROWS    = 4'd8;
  localparam logic [3:0] TOP_DIGIT     = 4'd9;

  // microcode program addresses
  typedef logic [4:0] pc_t;
  localparam pc_t PC_IDLE   = 5'd0;
  localparam pc_t PC_INIT   = 5'd1;
  localparam pc_t PC_CTRL   = 5'd4;
  localparam pc_t PC_CHAR   = 5'd6;
  localparam pc_t PC_CURSOR = 5'd7;
  localparam pc_t PC_CLEAR  = 5'd8;
  localparam pc_t PC_HOME   = 5'd9;
  localparam pc_t PC_SHIFT  = 5'd10;
  localparam pc_t PC_GLYPH  = 5'd12;
  localparam pc_t PC_NUMBER = 5'd15;

  typedef enum logic [1:0] {EM_NONE, EM_ALWAYS, EM_NEG, EM_DIGIT} emit_t;

  typedef enum logic [3:0] {
    SRC_CTRL, SRC_FSET, SRC_CLEAR, SRC_HOME, SRC_CHAR, SRC_CURSOR,
    SRC_SHIFT, SRC_CGADDR, SRC_ROW, SRC_MINUS, SRC_DIGIT
  } src_t;

  typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_CNT1, LAST_K0} last_t;

  typedef enum logic [2:0] {
    SQ_NEXT, SQ_DONE, SQ_DISPATCH, SQ_SKIP_CNT0, SQ_SKIP_SLOT, SQ_LOOP_CNT, SQ_LOOP_DIGIT
  } seq_t;

  typedef enum logic [1:0] {ACT_NONE, ACT_CNT8, ACT_ROWSHIFT} act_t;

  typedef struct packed {
    emit_t emit;
    src_t  src;
    logic  data;
    last_t last;
    seq_t  seq;
    act_t  act;
  } ctl_t;

  // digit unit control and status
  typedef struct packed {
    logic load;
    logic adv;
  } dig_ctl_t;

  typedef struct packed {
    logic       ge;
    logic       want;
    logic       k_zero;
    logic [3:0] digit;
  } dig_stat_t;

  function automatic ctl_t cw(emit_t e, src_t s, logic d, last_t l, seq_t q, act_t a);
    ctl_t c;
    c.emit = e;
    c.src  = s;
    c.data = d;
    c.last = l;
    c.seq  = q;
    c.act  = a;
    return c;
  endfunction

  // control store
  function automatic ctl_t ucode(pc_t pc);
    ctl_t c;
    case (pc)
      PC_IDLE:          c = cw(EM_NONE,   SRC_CLEAR,  1'b0, LAST_NO,   SQ_DISPATCH,   ACT_NONE);
      PC_INIT:          c = cw(EM_ALWAYS, SRC_CTRL,   1'b0, LAST_NO,   SQ_NEXT,       ACT_NONE);
      PC_INIT + 5'd1:   c = cw(EM_ALWAYS, SRC_FSET,   1'b0, LAST_NO,   SQ_NEXT,       ACT_NONE);
      PC_INIT + 5'd2:   c = cw(EM_ALWAYS, SRC_CLEAR,  1'b0, LAST_YES,  SQ_DONE,       ACT_NONE);
      PC_CTRL:          c = cw(EM_ALWAYS, SRC_CTRL,   1'b0, LAST_NO,   SQ_NEXT,       ACT_NONE);
      PC_CTRL + 5'd1:   c = cw(EM_ALWAYS, SRC_FSET,   1'b0, LAST_YES,  SQ_DONE,       ACT_NONE);
      PC_CHAR:          c = cw(EM_ALWAYS, SRC_CHAR,   1'b1, LAST_YES,  SQ_DONE,       ACT_NONE);
      PC_CURSOR:        c = cw(EM_ALWAYS, SRC_CURSOR, 1'b0, LAST_YES,  SQ_DONE,       ACT_NONE);
      PC_CLEAR:         c = cw(EM_ALWAYS, SRC_CLEAR,  1'b0, LAST_YES,  SQ_DONE,       ACT_NONE);
      PC_HOME:          c = cw(EM_ALWAYS, SRC_HOME,   1'b0, LAST_YES,  SQ_DONE,       ACT_NONE);
      PC_SHIFT:         c = cw(EM_NONE,   SRC_SHIFT,  1'b0, LAST_NO,   SQ_SKIP_CNT0,  ACT_NONE);
      PC_SHIFT + 5'd1:  c = cw(EM_ALWAYS, SRC_SHIFT,  1'b0, LAST_CNT1, SQ_LOOP_CNT,   ACT_NONE);
      PC_GLYPH:         c = cw(EM_NONE,   SRC_CGADDR, 1'b0, LAST_NO,   SQ_SKIP_SLOT,  ACT_NONE);
      PC_GLYPH + 5'd1:  c = cw(EM_ALWAYS, SRC_CGADDR, 1'b0, LAST_NO,   SQ_NEXT,       ACT_CNT8);
      PC_GLYPH + 5'd2:  c = cw(EM_ALWAYS, SRC_ROW,    1'b1, LAST_CNT1, SQ_LOOP_CNT,   ACT_ROWSHIFT);
      PC_NUMBER:        c = cw(EM_NEG,    SRC_MINUS,  1'b1, LAST_NO,   SQ_NEXT,       ACT_NONE);
      PC_NUMBER + 5'd1: c = cw(EM_DIGIT,  SRC_DIGIT,  1'b1, LAST_K0,   SQ_LOOP_DIGIT, ACT_NONE);
      default:          c = cw(EM_NONE,   SRC_CLEAR,  1'b0, LAST_NO,   SQ_DONE,       ACT_NONE);
    endcase
    return c;
  endfunction

  // dispatch table
  function automatic pc_t entry(logic [3:0] req);
    pc_t p;
    case (req) inside
      REQ_INIT:                       p = PC_INIT;
      REQ_CONTROL:                    p = PC_CTRL;
      REQ_CHAR:                       p = PC_CHAR;
      REQ_NUMBER:                     p = PC_NUMBER;
      REQ_CURSOR:                     p = PC_CURSOR;
      REQ_CLEAR:                      p = PC_CLEAR;
      REQ_HOME:                       p = PC_HOME;
      [REQ_DISP_LEFT:REQ_CUR_RGHT]:   p = PC_SHIFT;
      REQ_GLYPH:                      p = PC_GLYPH;
      default:                        p = PC_IDLE;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] shift_cmd(logic [3:0] req);
    logic [7:0] b;
    case (req)
      REQ_DISP_LEFT: b = CMD_DISP_LEFT;
      REQ_DISP_RGHT: b = CMD_DISP_RGHT;
      REQ_CUR_LEFT:  b = CMD_CUR_LEFT;
      default:       b = CMD_CUR_RGHT;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] pow10(logic [3:0] k);
    logic [31:0] p;
    case (k)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

>>> src/clce_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clce_if
// Channel interfaces: request items, bus write items and register writes.
// ----------------------------------------------------------------------------
interface clce_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [7:0]  char_code;
  logic signed [31:0] number_value;
  logic        row_index;
  logic [5:0]  column_index;
  logic [7:0]  repeat_count;
  logic [3:0]  glyph_slot;
  logic [63:0] glyph_rows;

  modport source (output valid, req_type, char_code, number_value, row_index,
                  column_index, repeat_count, glyph_slot, glyph_rows, input ready);
  modport sink   (input valid, req_type, char_code, number_value, row_index,
                  column_index, repeat_count, glyph_slot, glyph_rows, output ready);
endinterface

interface clce_wr_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] bus_byte;
  logic       last_write;

  modport source (output valid, is_data, bus_byte, last_write, input ready);
  modport sink   (input valid, is_data, bus_byte, last_write, output ready);
endinterface

interface clce_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] addr;
  logic       data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

>>> src/char_lcd_command_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_command_encoder_top
// Character LCD command encoder: a microcoded sequencer turns each request
// item into a run of bus write items and marks the last one.
// ----------------------------------------------------------------------------
//   port    dir   item
//   in_if   sink  request (type, char, number, cursor, shift count, glyph)
//   out_if  src   bus write (is_data, bus_byte, last_write)
//   cfg_if  sink  register write (addr, data), always ready
//
// one request at a time: the sequencer dispatches it, then steps through
// its writes; number requests also step through each power-of-ten
// subtraction, and shifts and glyphs start with a skip check
// a one-entry output register lets a write wait while the sequencer moves on
// a stalled output holds the sequencer; reset returns it to idle
// ----------------------------------------------------------------------------
module char_lcd_command_encoder_top
  import clce_pkg::*;
#(
  parameter int MAX_REPEAT = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  clce_req_if.sink   in_if,
  clce_wr_if.source  out_if,
  clce_cfg_if.sink   cfg_if
);

  localparam int CLOG_W = $clog2(MAX_REPEAT + 1);
  localparam int CNT_W  = (CLOG_W > 4) ? CLOG_W : 4;

  pc_t             pc_r, pc_nxt;
  ctl_t            ctl;
  logic [3:0]      req_r;
  logic [7:0]      char_r;
  logic            row_r;
  logic [5:0]      col_r;
  logic [3:0]      slot_r;
  logic [63:0]     rows_r;
  logic            neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_load;

  logic disp_r, cur_r, blink_r, two_r, tall_r, wide_r;

  logic       out_valid_r;
  logic       out_is_data_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       accept;
  logic       want, can_emit, stall, emit_fire, emit_last, adv;
  logic       cnt_one;
  logic [7:0] src_byte;
  logic [31:0] mag_in;
  dig_ctl_t   dctl;
  dig_stat_t  dstat;

  assign ctl       = ucode(pc_r);
  assign in_if.ready  = (pc_r == PC_IDLE);
  assign accept    = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign cnt_one   = (cnt_r == CNT_W'(1));
  assign cnt_load  = (in_if.repeat_count > 8'(MAX_REPEAT)) ? CNT_W'(MAX_REPEAT)
                                                           : CNT_W'(in_if.repeat_count);
  assign mag_in    = in_if.number_value[31] ? (~in_if.number_value + 32'd1)
                                            : in_if.number_value;

  // emit decision
  always_comb begin
    case (ctl.emit)
      EM_ALWAYS: want = 1'b1;
      EM_NEG:    want = neg_r;
      EM_DIGIT:  want = !dstat.ge && dstat.want;
      default:   want = 1'b0;
    endcase
    case (ctl.last)
      LAST_YES:  emit_last = 1'b1;
      LAST_CNT1: emit_last = cnt_one;
      LAST_K0:   emit_last = dstat.k_zero;
      default:   emit_last = 1'b0;
    endcase
  end

  assign can_emit  = !out_valid_r || out_if.ready;
  assign stall     = want && !can_emit;
  assign emit_fire = want && can_emit;
  assign adv       = !stall && (pc_r != PC_IDLE);

  assign dctl.load = accept;
  assign dctl.adv  = adv && (ctl.emit == EM_DIGIT);

  clce_digit u_digit (
    .clk    (clk),
    .ctl    (dctl),
    .mag_in (mag_in),
    .stat   (dstat)
  );

  // byte source
  always_comb begin
    case (ctl.src)
      SRC_CTRL:   src_byte = CMD_DISP_CTRL | {5'b0, disp_r, cur_r, blink_r};
      SRC_FSET:   src_byte = (wide_r ? CMD_FSET_8BIT : CMD_FSET_4BIT) |
                             {4'b0, two_r, tall_r, 2'b0};
      SRC_CLEAR:  src_byte = CMD_CLEAR;
      SRC_HOME:   src_byte = CMD_HOME;
      SRC_CHAR:   src_byte = char_r;
      SRC_CURSOR: src_byte = {1'b1, row_r, col_r};
      SRC_SHIFT:  src_byte = shift_cmd(req_r);
      SRC_CGADDR: src_byte = {2'b01, slot_r[2:0], 3'b000};
      SRC_ROW:    src_byte = rows_r[7:0];
      SRC_MINUS:  src_byte = CHAR_MINUS;
      SRC_DIGIT:  src_byte = CHAR_ZERO | {4'b0, dstat.digit};
      default:    src_byte = 8'h00;
    endcase
  end

  // sequencer next step
  always_comb begin
    pc_nxt = pc_r;
    case (ctl.seq)
      SQ_DISPATCH:   pc_nxt = accept ? entry(in_if.req_type) : PC_IDLE;
      SQ_NEXT:       pc_nxt = adv ? pc_r + 5'd1 : pc_r;
      SQ_DONE:       pc_nxt = adv ? PC_IDLE : pc_r;
      SQ_SKIP_CNT0:  pc_nxt = (cnt_r == '0) ? PC_IDLE : pc_r + 5'd1;
      SQ_SKIP_SLOT:  pc_nxt = slot_r[3] ? PC_IDLE : pc_r + 5'd1;
      SQ_LOOP_CNT:   pc_nxt = (adv && cnt_one) ? PC_IDLE : pc_r;
      SQ_LOOP_DIGIT: pc_nxt = (adv && !dstat.ge && dstat.k_zero) ? PC_IDLE : pc_r;
      default:       pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // request fields and loop counters
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_if.req_type;
      char_r <= in_if.char_code;
      row_r  <= in_if.row_index;
      col_r  <= in_if.column_index;
      slot_r <= in_if.glyph_slot;
      rows_r <= in_if.glyph_rows;
      neg_r  <= in_if.number_value[31];
      cnt_r  <= cnt_load;
    end else if (adv) begin
      if (ctl.act == ACT_CNT8) begin
        cnt_r <= CNT_W'(GLYPH_ROWS);
      end else if (ctl.seq == SQ_LOOP_CNT) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (ctl.act == ACT_ROWSHIFT) begin
        rows_r <= {8'h00, rows_r[63:8]};
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r  <= 1'b0;
      cur_r   <= 1'b0;
      blink_r <= 1'b0;
      two_r   <= 1'b0;
      tall_r  <= 1'b0;
      wide_r  <= 1'b1;
    end else if (cfg_if.valid) begin
      case (cfg_if.addr)
        CFG_DISPLAY_ON:   disp_r  <= cfg_if.data;
        CFG_CURSOR_ON:    cur_r   <= cfg_if.data;
        CFG_CURSOR_BLINK: blink_r <= cfg_if.data;
        CFG_TWO_LINES:    two_r   <= cfg_if.data;
        CFG_TALL_FONT:    tall_r  <= cfg_if.data;
        CFG_WIDE_BUS:     wide_r  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_is_data_r <= ctl.data;
      out_byte_r    <= src_byte;
      out_last_r    <= emit_last;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.is_data    = out_is_data_r;
  assign out_if.bus_byte   = out_byte_r;
  assign out_if.last_write = out_last_r;

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && emit_last |=> pc_r == PC_IDLE)
    else $error("sequencer kept running after last write");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == PC_IDLE |-> !emit_fire)
    else $error("write emitted while idle");

  a_loop_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r != PC_IDLE && ctl.seq == SQ_LOOP_CNT |-> cnt_r != '0)
    else $error("repeat loop entered with zero count");

endmodule

>>> src/clce_digit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clce_digit
// Decimal digit unit: peels digits off a 32-bit magnitude, most significant
// first, by subtracting at most one power of ten per cycle in which it is advanced.
// ----------------------------------------------------------------------------
module clce_digit
  import clce_pkg::*;
(
  input  logic        clk,
  input  dig_ctl_t    ctl,
  input  logic [31:0] mag_in,
  output dig_stat_t   stat
);

  logic [31:0] mag_r;
  logic [3:0]  k_r;
  logic [3:0]  digit_r;
  logic        started_r;
  logic [31:0] pw;

  assign pw          = pow10(k_r);
  assign stat.ge     = (mag_r >= pw);
  assign stat.k_zero = (k_r == 4'd0);
  assign stat.want   = (digit_r != 4'd0) || started_r || (k_r == 4'd0);
  assign stat.digit  = digit_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag_r     <= mag_in;
      k_r       <= TOP_DIGIT;
      digit_r   <= 4'd0;
      started_r <= 1'b0;
    end else if (ctl.adv) begin
      if (stat.ge) begin
        mag_r   <= mag_r - pw;
        digit_r <= digit_r + 4'd1;
      end else begin
        digit_r   <= 4'd0;
        started_r <= started_r | stat.want;
        if (!stat.k_zero) begin
          k_r <= k_r - 4'd1;
        end
      end
    end
  end

endmodule

>>> bench/lcd_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_write_checker
// Watches the request, bus write and register channels of the LCD command
// encoder. It keeps its own copy of the display and function-set flags,
// expands every accepted request into the bus writes it should cause, and
// compares each accepted write, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module lcd_write_checker
  import clce_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  clce_req_if  req_mon,
  clce_wr_if   wr_mon,
  clce_cfg_if  cfg_mon,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last_write;
  } lcd_write_t;

  localparam int         MAX_REPEAT    = 64;
  localparam int         GLYPH_SLOTS   = 8;
  localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  logic display_on, cursor_on, cursor_blink, two_lines, tall_font, wide_bus;
  lcd_write_t expected_writes[$];
  int mismatch_count = 0;
  int queued_writes  = 0;

  assign mismatches = mismatch_count;
  assign pending    = queued_writes;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic lcd_write_t cmd(input logic [7:0] b);
    lcd_write_t w;
    w.is_data    = 1'b0;
    w.bus_byte   = b;
    w.last_write = 1'b0;
    return w;
  endfunction

  function automatic lcd_write_t dat(input logic [7:0] b);
    lcd_write_t w;
    w = cmd(b);
    w.is_data = 1'b1;
    return w;
  endfunction

  function automatic logic [7:0] display_control();
    return CMD_DISP_CTRL | {5'b0, display_on, cursor_on, cursor_blink};
  endfunction

  function automatic logic [7:0] function_set();
    return (wide_bus ? CMD_FSET_8BIT : CMD_FSET_4BIT) | {4'b0, two_lines, tall_font, 2'b0};
  endfunction

  // expands the request on the input channel into its run of bus writes
  task automatic encode_request();
    lcd_write_t run[$];
    logic [31:0] magnitude;
    logic [3:0]  digits[$];
    logic [7:0]  shift_byte;
    int          count;
    case (req_mon.req_type)
      REQ_INIT: begin
        run.push_back(cmd(display_control()));
        run.push_back(cmd(function_set()));
        run.push_back(cmd(CMD_CLEAR));
      end
      REQ_CONTROL: begin
        run.push_back(cmd(display_control()));
        run.push_back(cmd(function_set()));
      end
      REQ_CHAR: run.push_back(dat(req_mon.char_code));
      REQ_NUMBER: begin
        magnitude = req_mon.number_value;
        if (magnitude[31]) begin
          run.push_back(dat(CHAR_MINUS));
          magnitude = -magnitude;
        end
        do begin
          digits.push_front(4'(magnitude % 10));
          magnitude = magnitude / 10;
        end while (magnitude != 0);
        foreach (digits[i]) run.push_back(dat(CHAR_ZERO + 8'(digits[i])));
      end
      REQ_CURSOR:
        run.push_back(cmd(CMD_SET_DDRAM | {1'b0, req_mon.row_index, req_mon.column_index}));
      REQ_CLEAR: run.push_back(cmd(CMD_CLEAR));
      REQ_HOME:  run.push_back(cmd(CMD_HOME));
      REQ_DISP_LEFT, REQ_DISP_RGHT, REQ_CUR_LEFT, REQ_CUR_RGHT: begin
        case (req_mon.req_type)
          REQ_DISP_LEFT: shift_byte = CMD_DISP_LEFT;
          REQ_DISP_RGHT: shift_byte = CMD_DISP_RGHT;
          REQ_CUR_LEFT:  shift_byte = CMD_CUR_LEFT;
          default:       shift_byte = CMD_CUR_RGHT;
        endcase
        count = (req_mon.repeat_count > MAX_REPEAT) ? MAX_REPEAT : int'(req_mon.repeat_count);
        repeat (count) run.push_back(cmd(shift_byte));
      end
      REQ_GLYPH: begin
        if (req_mon.glyph_slot < GLYPH_SLOTS) begin
          run.push_back(cmd(CMD_SET_CGRAM | {2'b0, req_mon.glyph_slot[2:0], 3'b0}));
          for (int i = 0; i < 8; i++) run.push_back(dat(req_mon.glyph_rows[8*i +: 8]));
        end
      end
      default: ;
    endcase
    if (run.size() > 0) run[run.size() - 1].last_write = 1'b1;
    foreach (run[i]) expected_writes.push_back(run[i]);
  endtask

  always @(posedge clk) begin : monitor
    lcd_write_t want;
    if (!rst_n) begin
      display_on   = 1'b0;
      cursor_on    = 1'b0;
      cursor_blink = 1'b0;
      two_lines    = 1'b0;
      tall_font    = 1'b0;
      wide_bus     = 1'b1;
      expected_writes.delete();
    end else begin
      if (wr_mon.valid && wr_mon.ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write is_data=%0b byte=%02h last=%0b",
                                    wr_mon.is_data, wr_mon.bus_byte, wr_mon.last_write));
        end else begin
          want = expected_writes.pop_front();
          if (wr_mon.is_data !== want.is_data)
            report_mismatch($sformatf("is_data %0b, expected %0b", wr_mon.is_data,
                                      want.is_data));
          if (wr_mon.bus_byte !== want.bus_byte)
            report_mismatch($sformatf("bus_byte %02h, expected %02h", wr_mon.bus_byte,
                                      want.bus_byte));
          if (wr_mon.last_write !== want.last_write)
            report_mismatch($sformatf("last_write %0b, expected %0b", wr_mon.last_write,
                                      want.last_write));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.addr)
          CFG_DISPLAY_ON:   display_on   = cfg_mon.data;
          CFG_CURSOR_ON:    cursor_on    = cfg_mon.data;
          CFG_CURSOR_BLINK: cursor_blink = cfg_mon.data;
          CFG_TWO_LINES:    two_lines    = cfg_mon.data;
          CFG_TALL_FONT:    tall_font    = cfg_mon.data;
          CFG_WIDE_BUS:     wide_bus     = cfg_mon.data;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) encode_request();
    end
    queued_writes = expected_writes.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the LCD command encoder with a directed set of requests and then
// phases of random requests under changing display and function-set flags,
// with random idle cycles on both channels. A checker beside the block
// predicts and compares every bus write; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb
  import clce_pkg::*;
();

  typedef struct {
    logic [3:0]         req_type;
    logic [7:0]         char_code;
    logic signed [31:0] number_value;
    logic               row_index;
    logic [5:0]         column_index;
    logic [7:0]         repeat_count;
    logic [3:0]         glyph_slot;
    logic [63:0]        glyph_rows;
  } lcd_request_t;

  localparam logic [3:0] REQ_FIRST_UNUSED = REQ_GLYPH + 4'd1;
  localparam logic [3:0] REQ_LAST_CODE    = 4'hF;
  localparam int         QUIET_CYCLES     = 200;
  localparam int         RANDOM_PHASES    = 8;
  localparam int         ITEMS_PER_PHASE  = 26;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic no_idle = 1'b0;
  int   mismatches;
  int   pending;

  clce_req_if req_ch();
  clce_wr_if  wr_ch();
  clce_cfg_if cfg_ch();

  char_lcd_command_encoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (wr_ch),
    .cfg_if (cfg_ch)
  );

  lcd_write_checker write_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_ch),
    .wr_mon     (wr_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic lcd_request_t random_fields();
    lcd_request_t r;
    r.req_type     = 4'($urandom);
    r.char_code    = 8'($urandom);
    r.number_value = $urandom;
    r.row_index    = 1'($urandom);
    r.column_index = 6'($urandom);
    r.repeat_count = 8'($urandom);
    r.glyph_slot   = 4'($urandom);
    r.glyph_rows   = {$urandom, $urandom};
    return r;
  endfunction

  task automatic send_request(input lcd_request_t r);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.req_type;
    req_ch.char_code    <= r.char_code;
    req_ch.number_value <= r.number_value;
    req_ch.row_index    <= r.row_index;
    req_ch.column_index <= r.column_index;
    req_ch.repeat_count <= r.repeat_count;
    req_ch.glyph_slot   <= r.glyph_slot;
    req_ch.glyph_rows   <= r.glyph_rows;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_directed(input logic [3:0] kind, input logic [31:0] arg,
                               input logic [63:0] rows);
    lcd_request_t r;
    r = random_fields();
    r.req_type = kind;
    case (kind)
      REQ_CHAR:   r.char_code = arg[7:0];
      REQ_NUMBER: r.number_value = arg;
      REQ_CURSOR: {r.row_index, r.column_index} = arg[6:0];
      REQ_GLYPH: begin
        r.glyph_slot = arg[3:0];
        r.glyph_rows = rows;
      end
      default:    r.repeat_count = arg[7:0];
    endcase
    send_request(r);
  endtask

  task automatic send_random_request();
    lcd_request_t r;
    int pick;
    int scale;
    r = random_fields();
    pick = $urandom_range(0, 24);
    if (pick < 12) r.req_type = 4'(pick);
    else if (pick < 16) r.req_type = REQ_NUMBER;
    else if (pick < 19) r.req_type = REQ_DISP_LEFT + 4'($urandom_range(0, 3));
    else if (pick < 22) r.req_type = REQ_GLYPH;
    else r.req_type = REQ_FIRST_UNUSED + 4'($urandom_range(0, 3));
    // short shift runs and valid glyph slots most of the time
    if ($urandom_range(0, 5) != 0) r.repeat_count = 8'($urandom_range(0, 8));
    if ($urandom_range(0, 4) != 0) r.glyph_slot = 4'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: ;
      1: r.number_value = $urandom_range(0, 99);
      2: r.number_value = 0 - int'($urandom_range(0, 999));
      3: begin
        // trailing zeros
        r.number_value = $urandom_range(1, 9);
        scale = $urandom_range(0, 9);
        repeat (scale) r.number_value = r.number_value * 10;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: r.number_value = 32'h8000_0000;
          1: r.number_value = 32'h7FFF_FFFF;
          2: r.number_value = 0;
          default: r.number_value = -1;
        endcase
      end
      default: r.number_value = $urandom_range(0, 99999);
    endcase
    send_request(r);
  endtask

  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [5:0] bits);
    for (int i = CFG_DISPLAY_ON; i <= CFG_WIDE_BUS; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.addr  <= 3'(i);
      cfg_ch.data  <= bits[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // write side: random stalls before each item
  initial begin
    int gap;
    wr_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_cycles();
      if (gap > 0) begin
        wr_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      wr_ch.ready <= 1'b1;
      do @(posedge clk); while (!wr_ch.valid);
    end
  end

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_INIT;
    req_ch.char_code    = '0;
    req_ch.number_value = '0;
    req_ch.row_index    = 1'b0;
    req_ch.column_index = '0;
    req_ch.repeat_count = '0;
    req_ch.glyph_slot   = '0;
    req_ch.glyph_rows   = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = CFG_DISPLAY_ON;
    cfg_ch.data         = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests under the reset flags
    send_directed(REQ_INIT, 0, 0);
    send_directed(REQ_CONTROL, 0, 0);
    send_directed(REQ_CHAR, 32'h00, 0);
    send_directed(REQ_CHAR, 32'hFF, 0);
    send_directed(REQ_NUMBER, 32'd0, 0);
    send_directed(REQ_NUMBER, 32'h7FFF_FFFF, 0);
    send_directed(REQ_NUMBER, 32'h8000_0000, 0);
    send_directed(REQ_NUMBER, 32'hFFFF_FFFF, 0);
    send_directed(REQ_NUMBER, 32'd1000000000, 0);
    send_directed(REQ_NUMBER, -32'sd100, 0);
    send_directed(REQ_CURSOR, 32'h00, 0);
    send_directed(REQ_CURSOR, 32'h7F, 0);
    send_directed(REQ_CLEAR, 0, 0);
    send_directed(REQ_HOME, 0, 0);
    send_directed(REQ_DISP_LEFT, 32'd0, 0);
    send_directed(REQ_DISP_RGHT, 32'd1, 0);
    send_directed(REQ_CUR_LEFT, 32'd64, 0);
    send_directed(REQ_CUR_RGHT, 32'd65, 0);
    send_directed(REQ_DISP_LEFT, 32'd255, 0);
    send_directed(REQ_GLYPH, 32'd0, {64{1'b1}});
    send_directed(REQ_GLYPH, 32'd7, 64'h0);
    send_directed(REQ_GLYPH, 32'd8, {$urandom, $urandom});
    send_directed(REQ_GLYPH, 32'd15, {$urandom, $urandom});
    send_directed(REQ_FIRST_UNUSED, 0, 0);
    send_directed(REQ_LAST_CODE, 0, 0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_quiet();
      if (phase == 0) write_config(6'b111111);
      else if (phase == 1) write_config(6'b000000);
      else write_config(6'($urandom));
      no_idle = (phase == 2) || ($urandom_range(0, 3) == 0);
      send_directed(REQ_INIT, 0, 0);
      send_directed(REQ_CONTROL, 0, 0);
      repeat (ITEMS_PER_PHASE) send_random_request();
    end
    wait_quiet();

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
